FILE: hw/rtl/oad_pkg.sv
// shared types, constants and register indexes of the obstacle-avoid drive block
package oad_pkg;

	localparam int DIST_W = 16;
	localparam int HEAD_W = 16;
	localparam int TILT_W = 12;
	localparam int ANG_W = 15;
	localparam int CMD_W = 13;
	localparam int MODE_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int NUM_BANDS = 4;
	localparam logic [TILT_W-1:0] BAND_WIDTH = TILT_W'(100);
	localparam logic [3:0] GEAR_STEP = 4'd2;
	localparam logic [3:0] GEAR_TOP = 4'd10;
	localparam logic signed [CMD_W-1:0] TURN_DRIVE = CMD_W'(500);

	localparam logic [DIST_W-1:0] RST_FORWARD_THR = DIST_W'(320);
	localparam logic [DIST_W-1:0] RST_SIDE_THR = DIST_W'(320);
	localparam logic [ANG_W-1:0] RST_ESCAPE_ANGLE = ANG_W'(715);
	localparam logic [TILT_W-1:0] RST_TILT_UPPER = TILT_W'(2150);
	localparam logic [TILT_W-1:0] RST_TILT_LOWER = TILT_W'(1950);
	localparam logic [TILT_W-1:0] RST_BASE_SPEED = TILT_W'(100);
	localparam logic [TILT_W-1:0] RST_SPEED_CAP = TILT_W'(200);
	localparam logic [TILT_W-1:0] RST_TURN_RATE = TILT_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORWARD_THR = 3'd0,
		REG_SIDE_THR = 3'd1,
		REG_ESCAPE_ANGLE = 3'd2,
		REG_TILT_UPPER = 3'd3,
		REG_TILT_LOWER = 3'd4,
		REG_BASE_SPEED = 3'd5,
		REG_SPEED_CAP = 3'd6,
		REG_TURN_RATE = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [DIST_W-1:0] forward_threshold_mm;
		logic [DIST_W-1:0] side_threshold_mm;
		logic [ANG_W-1:0] escape_angle;
		logic [TILT_W-1:0] tilt_upper;
		logic [TILT_W-1:0] tilt_lower;
		logic [TILT_W-1:0] base_speed;
		logic [TILT_W-1:0] speed_cap;
		logic [TILT_W-1:0] user_turn_rate;
	} oad_cfg_t;

	typedef struct packed {
		logic [DIST_W-1:0] center_dist;
		logic [DIST_W-1:0] left_dist;
		logic [DIST_W-1:0] right_dist;
		logic signed [HEAD_W-1:0] heading;
		logic [TILT_W-1:0] pitch;
		logic [TILT_W-1:0] yaw_tilt;
	} oad_item_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] linear_cmd;
		logic signed [CMD_W-1:0] angular_cmd;
	} oad_drive_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] linear_cmd;
		logic signed [CMD_W-1:0] angular_cmd;
		logic [MODE_W-1:0] mode;
	} oad_result_t;

endpackage

FILE: hw/rtl/oad_if.sv
// valid/ready channel interfaces for sensor words and drive words
interface oad_sensor_if;
	import oad_pkg::*;
	logic valid;
	logic ready;
	logic [DIST_W-1:0] center_dist;
	logic [DIST_W-1:0] left_dist;
	logic [DIST_W-1:0] right_dist;
	logic signed [HEAD_W-1:0] heading;
	logic [TILT_W-1:0] pitch;
	logic [TILT_W-1:0] yaw_tilt;

	modport source (
		output valid, center_dist, left_dist, right_dist, heading, pitch, yaw_tilt,
		input ready
	);
	modport sink (
		input valid, center_dist, left_dist, right_dist, heading, pitch, yaw_tilt,
		output ready
	);
endinterface

interface oad_drive_if;
	import oad_pkg::*;
	logic valid;
	logic ready;
	logic signed [CMD_W-1:0] linear_cmd;
	logic signed [CMD_W-1:0] angular_cmd;
	logic [MODE_W-1:0] mode;

	modport source (
		output valid, linear_cmd, angular_cmd, mode,
		input ready
	);
	modport sink (
		input valid, linear_cmd, angular_cmd, mode,
		output ready
	);
endinterface

FILE: hw/rtl/oad_cfg_regs.sv
// configuration register file with plain write port
module oad_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [oad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [oad_pkg::CFG_DATA_W-1:0]     cfg_data,
	output oad_pkg::oad_cfg_t                  cfg
);
	import oad_pkg::*;

	oad_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.forward_threshold_mm <= RST_FORWARD_THR;
			cfg_q.side_threshold_mm <= RST_SIDE_THR;
			cfg_q.escape_angle <= RST_ESCAPE_ANGLE;
			cfg_q.tilt_upper <= RST_TILT_UPPER;
			cfg_q.tilt_lower <= RST_TILT_LOWER;
			cfg_q.base_speed <= RST_BASE_SPEED;
			cfg_q.speed_cap <= RST_SPEED_CAP;
			cfg_q.user_turn_rate <= RST_TURN_RATE;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				REG_FORWARD_THR: cfg_q.forward_threshold_mm <= cfg_data;
				REG_SIDE_THR: cfg_q.side_threshold_mm <= cfg_data;
				REG_ESCAPE_ANGLE: cfg_q.escape_angle <= cfg_data[ANG_W-1:0];
				REG_TILT_UPPER: cfg_q.tilt_upper <= cfg_data[TILT_W-1:0];
				REG_TILT_LOWER: cfg_q.tilt_lower <= cfg_data[TILT_W-1:0];
				REG_BASE_SPEED: cfg_q.base_speed <= cfg_data[TILT_W-1:0];
				REG_SPEED_CAP: cfg_q.speed_cap <= cfg_data[TILT_W-1:0];
				REG_TURN_RATE: cfg_q.user_turn_rate <= cfg_data[TILT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/oad_user_drive.sv
// user drive command from imu pitch and yaw: gear bands, capped speed, turn rate
module oad_user_drive (
	input  logic [oad_pkg::TILT_W-1:0] pitch,
	input  logic [oad_pkg::TILT_W-1:0] yaw_tilt,
	input  oad_pkg::oad_cfg_t          cfg,
	output oad_pkg::oad_drive_t        drive
);
	import oad_pkg::*;

	localparam int BAND_W = TILT_W + 2;

	logic [3:0] gear;
	logic [BAND_W-1:0] band_lo [NUM_BANDS];
	logic [NUM_BANDS-1:0] in_band;
	logic [TILT_W+3:0] raw_speed;
	logic [TILT_W-1:0] speed;
	logic signed [CMD_W-1:0] speed_s;
	logic signed [CMD_W-1:0] rate_s;

	always_comb begin
		for (int k = 0; k < NUM_BANDS; k++) begin
			band_lo[k] = BAND_W'(cfg.tilt_upper) + BAND_W'(k) * BAND_W'(BAND_WIDTH);
			in_band[k] = (BAND_W'(pitch) > band_lo[k]) &&
				(BAND_W'(pitch) < band_lo[k] + BAND_W'(BAND_WIDTH));
		end
	end

	// lowest band wins; outside every band runs in top gear
	always_comb begin
		gear = GEAR_TOP;
		for (int k = NUM_BANDS - 1; k >= 0; k--) begin
			if (in_band[k]) begin
				gear = 4'(k + 1) * GEAR_STEP;
			end
		end
	end

	assign raw_speed = cfg.base_speed * gear;
	assign speed = (raw_speed > (TILT_W+4)'(cfg.speed_cap)) ? cfg.speed_cap
		: raw_speed[TILT_W-1:0];
	assign speed_s = signed'(CMD_W'(speed));
	assign rate_s = signed'(CMD_W'(cfg.user_turn_rate));

	always_comb begin
		if (pitch > cfg.tilt_upper) begin
			drive.linear_cmd = speed_s;
		end else if (pitch < cfg.tilt_lower) begin
			drive.linear_cmd = -speed_s;
		end else begin
			drive.linear_cmd = '0;
		end
		if (yaw_tilt > cfg.tilt_upper) begin
			drive.angular_cmd = -rate_s;
		end else if (yaw_tilt < cfg.tilt_lower) begin
			drive.angular_cmd = rate_s;
		end else begin
			drive.angular_cmd = '0;
		end
	end

endmodule

FILE: hw/rtl/oad_fsm.sv
// avoidance state machine: mode, saved heading and held drive command
module oad_fsm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  oad_pkg::oad_item_t     item,
	input  oad_pkg::oad_cfg_t      cfg,
	input  oad_pkg::oad_drive_t    user,
	output oad_pkg::oad_result_t   result
);
	import oad_pkg::*;

	typedef enum logic [MODE_W-1:0] {
		MODE_CHOOSE = 2'd0,
		MODE_RIGHT = 2'd1,
		MODE_LEFT = 2'd2
	} mode_t;

	mode_t mode_q;
	logic signed [HEAD_W-1:0] saved_heading_q;
	logic signed [CMD_W-1:0] linear_q;
	logic signed [CMD_W-1:0] angular_q;

	logic signed [HEAD_W:0] head_diff;
	logic [HEAD_W:0] head_abs;
	logic escaped;
	logic left_close;
	logic right_close;

	assign head_diff = (HEAD_W+1)'(saved_heading_q) - (HEAD_W+1)'(item.heading);
	assign head_abs = head_diff[HEAD_W] ? (HEAD_W+1)'(-head_diff) : head_diff;
	assign escaped = head_abs >= (HEAD_W+1)'(cfg.escape_angle);
	assign left_close = item.left_dist < cfg.side_threshold_mm;
	assign right_close = item.right_dist < cfg.side_threshold_mm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CHOOSE;
			saved_heading_q <= '0;
			linear_q <= '0;
			angular_q <= '0;
		end else if (fire) begin
			case (mode_q)
				MODE_CHOOSE: begin
					// center exactly at the threshold leaves everything alone
					if (item.center_dist != cfg.forward_threshold_mm) begin
						if (left_close) begin
							saved_heading_q <= item.heading;
							mode_q <= MODE_RIGHT;
						end else if (right_close) begin
							saved_heading_q <= item.heading;
							mode_q <= MODE_LEFT;
						end else if (item.center_dist > cfg.forward_threshold_mm) begin
							linear_q <= user.linear_cmd;
							angular_q <= user.angular_cmd;
						end
					end
				end
				MODE_RIGHT, MODE_LEFT: begin
					if (escaped) begin
						mode_q <= MODE_CHOOSE;
					end else begin
						linear_q <= '0;
						angular_q <= (mode_q == MODE_RIGHT) ? -TURN_DRIVE : TURN_DRIVE;
					end
				end
				default: mode_q <= MODE_CHOOSE;
			endcase
		end
	end

	assign result.linear_cmd = linear_q;
	assign result.angular_cmd = angular_q;
	assign result.mode = mode_q;

endmodule

FILE: hw/rtl/obstacle_avoid_drive_fsm.sv
// top level of the reactive obstacle-avoidance drive controller
// usage:
//   sensor channel: one word per control tick (three sector distances, heading,
//   imu pitch and yaw). drive channel: one word back per sensor word with the
//   linear and angular command and the mode after that tick.
//   configuration: cfg_we with cfg_index and cfg_data writes one register in a
//   cycle; write only while no sensor word is in flight.
// path: an accepted sensor word waits in the input register until the result
//   register is free; then the mode logic takes it into the state and command
//   registers, which are the drive word itself.
// throughput: one word per cycle while the drive side takes words; the mode
//   state closes its loop each tick, so consecutive ticks follow without a gap.
// reset: mode returns to choose direction, heading and command are zeroed,
//   registers take their default values, both channels come up empty.
// stall: while the drive word waits, the input register holds one more word
//   and sensor ready drops once it is full; nothing is lost or repeated.
module obstacle_avoid_drive_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	oad_sensor_if.sink                     sensor,
	oad_drive_if.source                    drive,
	input  logic                           cfg_we,
	input  logic [oad_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [oad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import oad_pkg::*;

	oad_cfg_t cfg;
	oad_item_t item_s1;
	logic valid_s1;
	logic drive_valid_q;
	logic advance;
	logic fire;
	oad_drive_t user;
	oad_result_t result;

	oad_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register is free when empty or being taken
	assign advance = !drive_valid_q || drive.ready;
	assign fire = valid_s1 && advance;
	assign sensor.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sensor.ready) begin
			valid_s1 <= sensor.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			item_s1.center_dist <= sensor.center_dist;
			item_s1.left_dist <= sensor.left_dist;
			item_s1.right_dist <= sensor.right_dist;
			item_s1.heading <= sensor.heading;
			item_s1.pitch <= sensor.pitch;
			item_s1.yaw_tilt <= sensor.yaw_tilt;
		end
	end

	oad_user_drive u_user (
		.pitch    (item_s1.pitch),
		.yaw_tilt (item_s1.yaw_tilt),
		.cfg      (cfg),
		.drive    (user)
	);

	oad_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.user   (user),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_valid_q <= 1'b0;
		end else if (advance) begin
			drive_valid_q <= valid_s1;
		end
	end

	assign drive.valid = drive_valid_q;
	assign drive.linear_cmd = result.linear_cmd;
	assign drive.angular_cmd = result.angular_cmd;
	assign drive.mode = result.mode;

	// unused mode code never shows up
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		drive.mode != 2'd3)
		else $error("drive mode holds the unused code");

	// a right turn never flips straight into a left turn
	a_no_turn_flip: assert property (@(posedge clk) disable iff (!arst_n)
		drive.mode == 2'd1 |=> drive.mode != 2'd2)
		else $error("mode went from right turn to left turn");

	// a word in the input register waits while the result register is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a word during a stall");

	// state and command move only when a word passes
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(result))
		else $error("command changed without a word passing");

endmodule

FILE: bench/testbench.sv
// self-checking bench for the obstacle-avoid drive controller with its own mode predictor
`timescale 1ns / 100ps

module testbench;
	import oad_pkg::*;

	localparam logic [MODE_W-1:0] MODE_CHOOSE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LEFT = 2'd2;
	localparam int TURN_MRAD = 500;
	localparam int HEAD_SPAN = 25736;
	localparam int LIMIT_CYCLES = 400000;
	localparam int DIR_ROWS = 23;

	typedef struct packed {
		int center_mm;
		int left_mm;
		int right_mm;
		int hdg;
		int pitch;
		int yaw;
		int typed;
		int lin;
		int ang;
		int mode;
	} dir_row_t;

	// reset defaults throughout; rows with typed = 0 go through the predictor
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{320, 1000, 1000, 0, 2200, 2000, 1, 0, 0, MODE_CHOOSE},
		'{1000, 1000, 1000, 0, 2200, 2000, 1, 200, 0, MODE_CHOOSE},
		'{1000, 1000, 1000, 0, 2150, 2151, 1, 0, -1000, MODE_CHOOSE},
		'{1000, 1000, 1000, 0, 1949, 1949, 1, -200, 1000, MODE_CHOOSE},
		'{1000, 1000, 1000, 0, 4095, 0, 1, 200, 1000, MODE_CHOOSE},
		'{1000, 1000, 1000, 0, 0, 4095, 1, -200, -1000, MODE_CHOOSE},
		'{1000, 1000, 1000, 0, 2250, 1950, 1, 200, 0, MODE_CHOOSE},
		'{0, 1000, 1000, 0, 2200, 2000, 1, 200, 0, MODE_CHOOSE},
		'{65535, 319, 65535, 100, 2200, 2000, 1, 200, 0, MODE_RIGHT},
		'{65535, 0, 0, 400, 0, 0, 0, 0, 0, 0},
		'{1000, 1000, 1000, 815, 2200, 2000, 1, 0, -500, MODE_CHOOSE},
		'{1000, 1000, 319, -25736, 2200, 2000, 1, 0, -500, MODE_LEFT},
		'{0, 0, 0, -25022, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 25736, 0, 0, 1, 0, 500, MODE_CHOOSE},
		'{320, 0, 0, 0, 4095, 4095, 1, 0, 500, MODE_CHOOSE},
		'{100, 0, 0, -32768, 0, 0, 1, 0, 500, MODE_RIGHT},
		'{0, 0, 0, 32767, 0, 0, 1, 0, 500, MODE_CHOOSE},
		'{100, 320, 320, 0, 4095, 0, 1, 0, 500, MODE_CHOOSE},
		'{1000, 320, 320, 0, 2200, 4095, 1, 200, -1000, MODE_CHOOSE},
		'{1000, 100, 100, 0, 2200, 2000, 1, 200, -1000, MODE_RIGHT},
		'{0, 0, 0, -714, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 714, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, -715, 0, 0, 1, 0, -500, MODE_CHOOSE}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	oad_sensor_if sensor_ch();
	oad_drive_if drive_ch();

	obstacle_avoid_drive_fsm DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sensor(sensor_ch),
		.drive(drive_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	oad_cfg_t cfg;
	logic [MODE_W-1:0] mode_st;
	logic signed [HEAD_W-1:0] saved_hd;
	logic signed [CMD_W-1:0] lin_hold;
	logic signed [CMD_W-1:0] ang_hold;

	oad_result_t pending_drive[$];
	int words_sent;
	int words_checked;
	int mismatches;
	int turns_started;
	int settings_applied;
	int burst_left;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d drive words pending", cycles,
				pending_drive.size());
			$display("FAIL obstacle_avoid_drive_fsm");
			$finish;
		end
	end

	function automatic oad_result_t predict_tick(input oad_item_t it);
		int gear;
		int spd;
		int lo;
		int diff;
		oad_result_t res;
		if (mode_st == MODE_CHOOSE) begin
			if (it.center_dist != cfg.forward_threshold_mm) begin
				if (it.left_dist < cfg.side_threshold_mm) begin
					saved_hd = it.heading;
					mode_st = MODE_RIGHT;
					turns_started++;
				end else if (it.right_dist < cfg.side_threshold_mm) begin
					saved_hd = it.heading;
					mode_st = MODE_LEFT;
					turns_started++;
				end else if (it.center_dist > cfg.forward_threshold_mm) begin
					// pitch bands are open intervals above tilt_upper, anything else is top gear
					gear = 10;
					for (int k = 0; k < 4; k++) begin
						lo = int'(cfg.tilt_upper) + 100 * k;
						if (int'(it.pitch) > lo && int'(it.pitch) < lo + 100)
							gear = 2 * (k + 1);
					end
					spd = int'(cfg.base_speed) * gear;
					if (spd > int'(cfg.speed_cap))
						spd = int'(cfg.speed_cap);
					if (it.pitch > cfg.tilt_upper)
						lin_hold = CMD_W'(spd);
					else if (it.pitch < cfg.tilt_lower)
						lin_hold = CMD_W'(-spd);
					else
						lin_hold = '0;
					if (it.yaw_tilt > cfg.tilt_upper)
						ang_hold = CMD_W'(-int'(cfg.user_turn_rate));
					else if (it.yaw_tilt < cfg.tilt_lower)
						ang_hold = CMD_W'(int'(cfg.user_turn_rate));
					else
						ang_hold = '0;
				end
			end
		end else if (mode_st == MODE_RIGHT || mode_st == MODE_LEFT) begin
			// plain difference, no wrap of the angle
			diff = int'(saved_hd) - int'(it.heading);
			if (diff < 0)
				diff = -diff;
			if (diff >= int'(cfg.escape_angle)) begin
				mode_st = MODE_CHOOSE;
			end else begin
				lin_hold = '0;
				ang_hold = (mode_st == MODE_RIGHT) ? CMD_W'(-TURN_MRAD) : CMD_W'(TURN_MRAD);
			end
		end else begin
			mode_st = MODE_CHOOSE;
		end
		res.linear_cmd = lin_hold;
		res.angular_cmd = ang_hold;
		res.mode = mode_st;
		return res;
	endfunction

	function automatic logic [TILT_W-1:0] tilt_pick();
		int v;
		case ($urandom_range(0, 3))
			0: v = int'($urandom_range(0, 4095));
			1: v = int'(cfg.tilt_upper) + int'($urandom_range(0, 410)) - 5;
			2: v = int'(cfg.tilt_lower) + int'($urandom_range(0, 20)) - 10;
			default: v = int'(cfg.tilt_upper) + 100 * int'($urandom_range(0, 4))
				+ int'($urandom_range(0, 2)) - 1;
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[TILT_W-1:0];
	endfunction

	function automatic oad_item_t random_item();
		oad_item_t it;
		it.center_dist = 16'($urandom);
		it.left_dist = 16'($urandom);
		it.right_dist = 16'($urandom);
		if ($urandom_range(0, 9) == 0)
			it.heading = 16'($urandom);
		else
			it.heading = 16'(int'($urandom_range(0, 2 * HEAD_SPAN)) - HEAD_SPAN);
		it.pitch = tilt_pick();
		it.yaw_tilt = tilt_pick();
		return it;
	endfunction

	task automatic send_word(input oad_item_t it, input logic use_typed,
		input oad_result_t typed);
		oad_result_t predicted;
		sensor_ch.valid <= 1'b1;
		sensor_ch.center_dist <= it.center_dist;
		sensor_ch.left_dist <= it.left_dist;
		sensor_ch.right_dist <= it.right_dist;
		sensor_ch.heading <= it.heading;
		sensor_ch.pitch <= it.pitch;
		sensor_ch.yaw_tilt <= it.yaw_tilt;
		@(posedge clk);
		while (!sensor_ch.ready)
			@(posedge clk);
		predicted = predict_tick(it);
		pending_drive = {pending_drive, (use_typed ? typed : predicted)};
		words_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			sensor_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90)
				: $urandom_range(1, 10);
		end
	endtask

	task automatic drain_drive();
		sensor_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FORWARD_THR: cfg.forward_threshold_mm = val;
			REG_SIDE_THR: cfg.side_threshold_mm = val;
			REG_ESCAPE_ANGLE: cfg.escape_angle = val[ANG_W-1:0];
			REG_TILT_UPPER: cfg.tilt_upper = val[TILT_W-1:0];
			REG_TILT_LOWER: cfg.tilt_lower = val[TILT_W-1:0];
			REG_BASE_SPEED: cfg.base_speed = val[TILT_W-1:0];
			REG_SPEED_CAP: cfg.speed_cap = val[TILT_W-1:0];
			REG_TURN_RATE: cfg.user_turn_rate = val[TILT_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] fwd, input logic [15:0] side,
		input logic [15:0] esc, input logic [15:0] up, input logic [15:0] low,
		input logic [15:0] base, input logic [15:0] cap, input logic [15:0] rate);
		drain_drive();
		write_reg(REG_FORWARD_THR, fwd);
		write_reg(REG_SIDE_THR, side);
		write_reg(REG_ESCAPE_ANGLE, esc);
		write_reg(REG_TILT_UPPER, up);
		write_reg(REG_TILT_LOWER, low);
		write_reg(REG_BASE_SPEED, base);
		write_reg(REG_SPEED_CAP, cap);
		write_reg(REG_TURN_RATE, rate);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_applied++;
	endtask

	task automatic run_random(input int target);
		int done_items;
		int pick;
		int walk;
		int dir;
		int step;
		int ticks;
		oad_item_t it;
		done_items = 0;
		while (done_items < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// obstacle on one side, then a heading sweep until the turn lets go or 40 words are sent
				if (mode_st == MODE_CHOOSE) begin
					it = random_item();
					if (it.center_dist == cfg.forward_threshold_mm)
						it.center_dist = it.center_dist ^ 16'd1;
					if (cfg.side_threshold_mm != 0) begin
						if ($urandom_range(0, 1))
							it.left_dist = 16'($urandom_range(0, cfg.side_threshold_mm - 1));
						else
							it.right_dist = 16'($urandom_range(0, cfg.side_threshold_mm - 1));
					end
					send_word(it, 1'b0, '0);
					done_items++;
				end
				walk = int'(saved_hd);
				dir = $urandom_range(0, 1) ? 1 : -1;
				ticks = 0;
				while ((mode_st == MODE_RIGHT || mode_st == MODE_LEFT) && ticks < 40) begin
					it = random_item();
					if ($urandom_range(0, 9) != 0) begin
						step = int'($urandom_range(0, cfg.escape_angle / 3 + 8));
						walk += dir * step;
						if (walk > HEAD_SPAN) begin
							walk = HEAD_SPAN;
							dir = -dir;
						end else if (walk < -HEAD_SPAN) begin
							walk = -HEAD_SPAN;
							dir = -dir;
						end
						it.heading = 16'(walk);
					end
					send_word(it, 1'b0, '0);
					done_items++;
					ticks++;
				end
			end else if (pick < 80) begin
				// clear path, imu drives
				repeat ($urandom_range(1, 8)) begin
					it = random_item();
					if (cfg.forward_threshold_mm != 16'hFFFF)
						it.center_dist = 16'($urandom_range(cfg.forward_threshold_mm + 1, 65535));
					it.left_dist = 16'($urandom_range(cfg.side_threshold_mm, 65535));
					it.right_dist = 16'($urandom_range(cfg.side_threshold_mm, 65535));
					send_word(it, 1'b0, '0);
					done_items++;
				end
			end else if (pick < 90) begin
				// center on or below the threshold with sides clear: command held
				it = random_item();
				if ($urandom_range(0, 1) || cfg.forward_threshold_mm == 0)
					it.center_dist = cfg.forward_threshold_mm;
				else
					it.center_dist = 16'($urandom_range(0, cfg.forward_threshold_mm - 1));
				it.left_dist = 16'($urandom_range(cfg.side_threshold_mm, 65535));
				it.right_dist = 16'($urandom_range(cfg.side_threshold_mm, 65535));
				send_word(it, 1'b0, '0);
				done_items++;
			end else begin
				it = random_item();
				it.pitch = 12'($urandom);
				it.yaw_tilt = 12'($urandom);
				send_word(it, 1'b0, '0);
				done_items++;
			end
		end
	endtask

	task automatic flag_mismatch(input string field, input int want, input int got);
		mismatches++;
		if (mismatches <= 10)
			$display("drive word %0d: %s expected %0d, got %0d", words_checked, field,
				want, got);
	endtask

	always @(posedge clk) begin : drive_check
		oad_result_t want;
		if (arst_n && drive_ch.valid && drive_ch.ready) begin
			if (pending_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("drive word %0d arrived with nothing pending", words_checked);
			end else begin
				want = pending_drive.pop_front();
				if (drive_ch.linear_cmd !== want.linear_cmd)
					flag_mismatch("linear_cmd", int'(want.linear_cmd), int'(drive_ch.linear_cmd));
				if (drive_ch.angular_cmd !== want.angular_cmd)
					flag_mismatch("angular_cmd", int'(want.angular_cmd),
						int'(drive_ch.angular_cmd));
				if (drive_ch.mode !== want.mode)
					flag_mismatch("mode", int'(want.mode), int'(drive_ch.mode));
			end
			words_checked++;
		end
	end

	// receiver: runs of full rate, random back-pressure, hard stalls, periodic stalls
	initial begin
		int seg_left;
		int seg_kind;
		seg_left = 0;
		seg_kind = 0;
		drive_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (seg_left == 0) begin
				seg_kind = $urandom_range(0, 3);
				seg_left = (seg_kind == 2) ? $urandom_range(1, 8) : $urandom_range(10, 60);
			end
			seg_left--;
			case (seg_kind)
				0: drive_ch.ready <= 1'b1;
				1: drive_ch.ready <= 1'($urandom_range(0, 1));
				2: drive_ch.ready <= 1'b0;
				default: drive_ch.ready <= (seg_left % 3 != 0);
			endcase
		end
	end

	initial begin
		oad_item_t it;
		oad_result_t typed;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FORWARD_THR;
		cfg_data <= '0;
		sensor_ch.valid <= 1'b0;
		sensor_ch.center_dist <= '0;
		sensor_ch.left_dist <= '0;
		sensor_ch.right_dist <= '0;
		sensor_ch.heading <= '0;
		sensor_ch.pitch <= '0;
		sensor_ch.yaw_tilt <= '0;
		cfg = '{forward_threshold_mm: 16'd320, side_threshold_mm: 16'd320,
			escape_angle: 15'd715, tilt_upper: 12'd2150, tilt_lower: 12'd1950,
			base_speed: 12'd100, speed_cap: 12'd200, user_turn_rate: 12'd1000};
		mode_st = MODE_CHOOSE;
		saved_hd = '0;
		lin_hold = '0;
		ang_hold = '0;
		words_sent = 0;
		turns_started = 0;
		settings_applied = 1;
		burst_left = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			it.center_dist = DIR_TABLE[i].center_mm[15:0];
			it.left_dist = DIR_TABLE[i].left_mm[15:0];
			it.right_dist = DIR_TABLE[i].right_mm[15:0];
			it.heading = DIR_TABLE[i].hdg[15:0];
			it.pitch = DIR_TABLE[i].pitch[11:0];
			it.yaw_tilt = DIR_TABLE[i].yaw[11:0];
			typed.linear_cmd = DIR_TABLE[i].lin[12:0];
			typed.angular_cmd = DIR_TABLE[i].ang[12:0];
			typed.mode = DIR_TABLE[i].mode[1:0];
			send_word(it, DIR_TABLE[i].typed != 0, typed);
		end
		run_random(250);

		// all ones, masked down to each register width
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF);
		run_random(150);
		program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_random(120);
		// a tick turns when center is nonzero and a side is below 65535; every turn ends on the next tick
		program_regs(16'd0, 16'd65535, 16'd0, 16'd4095, 16'd0, 16'd4095, 16'd4095,
			16'd4095);
		run_random(150);
		program_regs(16'd100, 16'd50, 16'd200, 16'd100, 16'd50, 16'd4095, 16'd4095,
			16'd4095);
		run_random(150);
		// crossed tilt limits
		program_regs(16'd500, 16'd400, 16'd900, 16'd1800, 16'd2300, 16'd150, 16'd700,
			16'd2000);
		run_random(200);
		repeat (4) begin
			program_regs(16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1200)),
				16'($urandom_range(0, 4000)), 16'($urandom_range(1000, 3000)),
				16'($urandom_range(900, 2900)), 16'($urandom_range(0, 600)),
				16'($urandom_range(0, 4095)), 16'($urandom_range(0, 4095)));
			run_random(210);
		end

		sensor_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d sensor words (%0d directed) under %0d register settings", words_sent,
			DIR_ROWS, settings_applied);
		$display("%0d drive words checked, %0d avoidance turns entered, %0d mismatches",
			words_checked, turns_started, mismatches);
		if (mismatches == 0 && pending_drive.size() == 0) begin
			$display("PASS obstacle_avoid_drive_fsm");
		end else begin
			$display("FAIL obstacle_avoid_drive_fsm");
		end
		$finish;
	end

endmodule
